### sv/rfbw_pkg.sv
// ----------------------------------------------------------------------------
// rfbw_pkg
// Shared constants, codes and controller/datapath interface types for the
// rotated 1bpp framebuffer box writer.
// ----------------------------------------------------------------------------
package rfbw_pkg;

    // Panel geometry and store layout (MSB-first, row after row)
    localparam int PANEL_WIDTH  = 800;
    localparam int PANEL_HEIGHT = 480;
    localparam int ROW_BYTES    = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_BYTES);

    // Coordinate widths: logical side never exceeds the larger panel side
    localparam int LOG_MAX = (PANEL_WIDTH > PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
    localparam int CW      = $clog2(LOG_MAX);
    // Signed width that holds every raw box bound before clamping
    localparam int SW      = 14;

    // Request modes
    localparam logic [1:0] MODE_PIXEL = 2'd0;
    localparam logic [1:0] MODE_BOX   = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    // Orientation codes
    localparam logic [1:0] ORIENT_PORTRAIT     = 2'd0;
    localparam logic [1:0] ORIENT_LANDSCAPE_CW = 2'd1;
    localparam logic [1:0] ORIENT_PORTRAIT_INV = 2'd2;
    localparam logic [1:0] ORIENT_LANDSCAPE_CC = 2'd3;

    // Border rectangles of an outlined box
    localparam logic [1:0] RECT_TOP    = 2'd0;
    localparam logic [1:0] RECT_BOTTOM = 2'd1;
    localparam logic [1:0] RECT_LEFT   = 2'd2;
    localparam logic [1:0] RECT_RIGHT  = 2'd3;

    typedef logic [CW-1:0]     t_coord;
    typedef logic [ADDR_W-1:0] t_addr;

    // Controller to datapath commands
    typedef struct packed {
        logic       load;    // latch request fields
        logic       setup;   // compute clamped bounds of the current rectangle
        logic [1:0] rect;    // rectangle being set up
        logic       run;     // walk the rectangle, one pixel per cycle
        logic       clear;   // write white at the clear pointer
        logic       finish;  // load the result register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic empty;     // current rectangle is clipped away entirely
        logic gen_last;  // pixel walker is on the last pixel
        logic busy;      // read-modify-write pipeline holds pixels
        logic clr_done;  // clear pointer at the last byte
    } t_sts;

endpackage

### sv/rfbw_ctrl.sv
// ----------------------------------------------------------------------------
// rfbw_ctrl
// Sequencer for the box writer: clearing pass, request intake, rectangle
// sequencing, pipeline drain and result handoff.
// ----------------------------------------------------------------------------
module rfbw_ctrl import rfbw_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_mode,
    input  logic        i_fill,
    input  logic [10:0] i_box_width,
    input  logic [10:0] i_box_height,
    output t_cmd        o_cmd,
    input  t_sts        i_sts
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SETUP  = 3'd2;
    localparam logic [2:0] S_RUN    = 3'd3;
    localparam logic [2:0] S_DRAIN  = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_FINISH = 3'd6;

    logic [2:0] r_state, n_state;
    logic [1:0] r_rect, n_rect;
    logic [1:0] r_mode, n_mode;
    logic       r_fill, n_fill;
    logic       r_out_valid, n_out_valid;

    // Next-state and command decode
    always_comb begin
        n_state     = r_state;
        n_rect      = r_rect;
        n_mode      = r_mode;
        n_fill      = r_fill;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        o_cmd.rect  = r_rect;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_mode     = i_mode;
                    n_fill     = i_fill;
                    n_rect     = RECT_TOP;
                    case (i_mode)
                        MODE_PIXEL: n_state = S_SETUP;
                        MODE_BOX: begin
                            if (i_box_width == '0 || i_box_height == '0) begin
                                n_state = S_FINISH;
                            end else begin
                                n_state = S_SETUP;
                            end
                        end
                        MODE_READ: n_state = S_READ;
                        default:   n_state = S_FINISH;
                    endcase
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_RUN;
            end
            S_RUN: begin
                o_cmd.run = 1'b1;
                if (i_sts.empty || i_sts.gen_last) begin
                    if (r_mode == MODE_BOX && !r_fill && r_rect != RECT_RIGHT) begin
                        n_rect  = r_rect + 2'd1;
                        n_state = S_SETUP;
                    end else begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy) begin
                    n_state = S_FINISH;
                end
            end
            S_READ: begin
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_rect      <= RECT_TOP;
            r_mode      <= MODE_PIXEL;
            r_fill      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rect      <= n_rect;
            r_mode      <= n_mode;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

### sv/rfbw_datapath.sv
// ----------------------------------------------------------------------------
// rfbw_datapath
// Request registers, rectangle clamping, pixel walker, rotation, byte address
// generation and the read-modify-write pipeline around the framebuffer memory.
// ----------------------------------------------------------------------------
module rfbw_datapath import rfbw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_sts               o_sts,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic [1:0]         i_mode,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic [10:0]        i_box_width,
    input  logic [10:0]        i_box_height,
    input  logic               i_fill,
    input  logic               i_black,
    input  logic [7:0]         i_border_top,
    input  logic [7:0]         i_border_bottom,
    input  logic [7:0]         i_border_left,
    input  logic [7:0]         i_border_right,
    input  logic [15:0]        i_read_address,
    output logic [7:0]         o_read_data,
    output logic               o_clipped
);

    // Orientation register
    logic [1:0] r_orient;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orient <= ORIENT_PORTRAIT;
        end else if (i_cfg_we) begin
            r_orient <= i_cfg_data;
        end
    end

    // Latched request
    logic [1:0]         r_mode;
    logic signed [11:0] r_pos_x, r_pos_y;
    logic [10:0]        r_box_width, r_box_height;
    logic               r_fill, r_black;
    logic [7:0]         r_bt, r_bb, r_bl, r_br;
    logic [15:0]        r_read_address;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode         <= i_mode;
            r_pos_x        <= i_pos_x;
            r_pos_y        <= i_pos_y;
            r_box_width    <= i_box_width;
            r_box_height   <= i_box_height;
            r_fill         <= i_fill;
            r_black        <= i_black;
            r_bt           <= i_border_top;
            r_bb           <= i_border_bottom;
            r_bl           <= i_border_left;
            r_br           <= i_border_right;
            r_read_address <= i_read_address;
        end
    end

    // Raw bounds of the current rectangle, half-open on the high side
    logic signed [SW-1:0] sx, sy, sw, sh, sbt, sbb, sbl, sbr;
    logic signed [SW-1:0] rx0, rx1, ry0, ry1;
    logic signed [SW-1:0] cx0, cx1, cy0, cy1;
    logic signed [SW-1:0] lw, lh;
    logic                 rect_empty;

    assign sx  = SW'(r_pos_x);
    assign sy  = SW'(r_pos_y);
    assign sw  = SW'(r_box_width);
    assign sh  = SW'(r_box_height);
    assign sbt = SW'(r_bt);
    assign sbb = SW'(r_bb);
    assign sbl = SW'(r_bl);
    assign sbr = SW'(r_br);

    // Logical size swaps with the portrait orientations
    always_comb begin
        if (r_orient == ORIENT_PORTRAIT || r_orient == ORIENT_PORTRAIT_INV) begin
            lw = SW'(PANEL_HEIGHT);
            lh = SW'(PANEL_WIDTH);
        end else begin
            lw = SW'(PANEL_WIDTH);
            lh = SW'(PANEL_HEIGHT);
        end
    end

    always_comb begin
        rx0 = sx;
        rx1 = sx + sw;
        ry0 = sy;
        ry1 = sy + sh;
        if (r_mode == MODE_PIXEL) begin
            rx1 = sx + SW'(1);
            ry1 = sy + SW'(1);
        end else if (!r_fill) begin
            case (i_cmd.rect)
                RECT_TOP: begin
                    ry1 = sy + sbt;
                end
                RECT_BOTTOM: begin
                    ry0 = sy + sh - sbb;
                end
                RECT_LEFT: begin
                    rx1 = sx + sbl;
                    ry0 = sy + sbt;
                    ry1 = sy + sh - sbb;
                end
                RECT_RIGHT: begin
                    rx0 = sx + sw - sbr;
                    ry0 = sy + sbt;
                    ry1 = sy + sh - sbb;
                end
                default: begin
                    rx1 = sx;
                end
            endcase
        end
    end

    // Clamp to the logical area
    assign cx0        = (rx0 < 0) ? '0 : rx0;
    assign cy0        = (ry0 < 0) ? '0 : ry0;
    assign cx1        = (rx1 > lw) ? lw : rx1;
    assign cy1        = (ry1 > lh) ? lh : ry1;
    assign rect_empty = (cx0 >= cx1) || (cy0 >= cy1);

    // Pixel walker: row by row inside the clamped rectangle
    logic   r_empty;
    t_coord r_x0, r_x_last, r_y_last, r_gx, r_gy;
    logic   gen_valid, gen_last;

    assign gen_valid = i_cmd.run && !r_empty;
    assign gen_last  = (r_gx == r_x_last) && (r_gy == r_y_last);

    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_empty  <= rect_empty;
            r_x0     <= CW'(cx0);
            r_gx     <= CW'(cx0);
            r_gy     <= CW'(cy0);
            r_x_last <= CW'(cx1 - SW'(1));
            r_y_last <= CW'(cy1 - SW'(1));
        end else if (gen_valid) begin
            if (r_gx == r_x_last) begin
                r_gx <= r_x0;
                r_gy <= r_gy + CW'(1);
            end else begin
                r_gx <= r_gx + CW'(1);
            end
        end
    end

    // Rotate logical to panel coordinates
    t_coord px, py;

    always_comb begin
        case (r_orient)
            ORIENT_PORTRAIT: begin
                px = r_gy;
                py = CW'(PANEL_HEIGHT - 1) - r_gx;
            end
            ORIENT_LANDSCAPE_CW: begin
                px = CW'(PANEL_WIDTH - 1) - r_gx;
                py = CW'(PANEL_HEIGHT - 1) - r_gy;
            end
            ORIENT_PORTRAIT_INV: begin
                px = CW'(PANEL_WIDTH - 1) - r_gy;
                py = r_gx;
            end
            default: begin
                px = r_gx;
                py = r_gy;
            end
        endcase
    end

    // Pipeline stage A: panel coordinates
    logic   r_a_valid;
    t_coord r_a_px, r_a_py;
    // Stage B: byte address and bit, memory read issued
    logic   r_b_valid;
    t_addr  r_b_idx;
    logic [2:0] r_b_bit;
    // Stage C: modify and write back
    logic   r_c_valid;
    t_addr  r_c_idx;
    logic [2:0] r_c_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= gen_valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_px  <= px;
        r_a_py  <= py;
        r_b_idx <= ADDR_W'(r_a_py * ROW_BYTES) + ADDR_W'(r_a_px >> 3);
        r_b_bit <= r_a_px[2:0];
        r_c_idx <= r_b_idx;
        r_c_bit <= r_b_bit;
    end

    // Clearing pass pointer
    t_addr r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clear) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
        end
    end

    // Framebuffer memory: one write port, one registered read port
    logic [7:0] r_mem [STORE_BYTES];
    logic [7:0] r_rdata, r_fwd_data;
    logic       r_fwd_hit;
    logic [7:0] rd_eff, pix_mask, pix_data, wr_data;
    t_addr      rd_addr, wr_addr;
    logic       wr_en;

    assign rd_addr  = (r_mode == MODE_READ) ? ADDR_W'(r_read_address) : r_b_idx;
    // Take the byte written last cycle when the read hit the same address
    assign rd_eff   = r_fwd_hit ? r_fwd_data : r_rdata;
    assign pix_mask = 8'h80 >> r_c_bit;
    assign pix_data = r_black ? (rd_eff & ~pix_mask) : (rd_eff | pix_mask);
    assign wr_en    = i_cmd.clear || r_c_valid;
    assign wr_addr  = i_cmd.clear ? r_clr_addr : r_c_idx;
    assign wr_data  = i_cmd.clear ? 8'hFF : pix_data;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata    <= r_mem[rd_addr];
        r_fwd_hit  <= r_c_valid && (r_c_idx == rd_addr);
        r_fwd_data <= pix_data;
    end

    // Result register
    logic       addr_ok;
    logic [7:0] r_out_read_data;
    logic       r_out_clipped;

    assign addr_ok = (32'(r_read_address) < STORE_BYTES);

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_read_data <= (r_mode == MODE_READ && addr_ok) ? rd_eff : 8'h00;
            r_out_clipped   <= (r_mode == MODE_PIXEL) && r_empty;
        end
    end

    assign o_read_data = r_out_read_data;
    assign o_clipped   = r_out_clipped;

    // Status back to the controller
    assign o_sts.empty    = r_empty;
    assign o_sts.gen_last = gen_last;
    assign o_sts.busy     = r_a_valid || r_b_valid || r_c_valid;
    assign o_sts.clr_done = (r_clr_addr == ADDR_W'(STORE_BYTES - 1));

endmodule

### sv/rotated_framebuffer_box_writer.sv
// ----------------------------------------------------------------------------
// rotated_framebuffer_box_writer
// 1bpp rotated framebuffer with pixel write, box fill/outline and byte read.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (i_in_valid / o_in_stall) carries mode, position, box
//   size, fill, color, border widths and read address. One request is worked
//   on at a time; o_in_stall is high from acceptance until its result has
//   been placed in the output register, and the next request is taken on
//   the cycle after that.
//   Result channel (o_out_valid / i_out_stall) returns one result per request:
//   the byte for a read, the clip flag for a pixel write, zeros otherwise.
//   After acceptance a read goes through the read state and then loads the
//   result; an empty box or the unused mode goes straight to loading the
//   result. A pixel write or a box sets up and walks each rectangle in turn
//   (one when filled, four for an outline), a rectangle clipped away giving
//   no pixels, then drains the read-modify-write pipeline and loads the
//   result. Pixels stream at one per cycle; a write-to-read bypass covers
//   back-to-back hits on the same byte.
//   Reset: orientation returns to portrait and a clearing pass writes white
//   to every byte with o_in_stall high throughout; i_cfg_we is honored.
//   Stall: a held result stays in the output register; the next request may
//   be accepted and worked on, and finishes once the register is free.
// ----------------------------------------------------------------------------
module rotated_framebuffer_box_writer import rfbw_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_mode,
    input  logic signed [11:0] i_pos_x,
    input  logic signed [11:0] i_pos_y,
    input  logic [10:0]        i_box_width,
    input  logic [10:0]        i_box_height,
    input  logic               i_fill,
    input  logic               i_black,
    input  logic [7:0]         i_border_top,
    input  logic [7:0]         i_border_bottom,
    input  logic [7:0]         i_border_left,
    input  logic [7:0]         i_border_right,
    input  logic [15:0]        i_read_address,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_read_data,
    output logic               o_clipped
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    rfbw_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_mode       (i_mode),
        .i_fill       (i_fill),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_cmd        (cmd),
        .i_sts        (sts)
    );

    // Geometry, address generation and framebuffer
    rfbw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_data      (i_cfg_data),
        .i_mode          (i_mode),
        .i_pos_x         (i_pos_x),
        .i_pos_y         (i_pos_y),
        .i_box_width     (i_box_width),
        .i_box_height    (i_box_height),
        .i_fill          (i_fill),
        .i_black         (i_black),
        .i_border_top    (i_border_top),
        .i_border_bottom (i_border_bottom),
        .i_border_left   (i_border_left),
        .i_border_right  (i_border_right),
        .i_read_address  (i_read_address),
        .o_read_data     (o_read_data),
        .o_clipped       (o_clipped)
    );

endmodule
